[hdl/hci_uart_h4_deframer_assert.svh]
// Assertion macros used by the checker of the H4 deframer.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef HCI_UART_H4_DEFRAMER_ASSERT_SVH
`define HCI_UART_H4_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define H4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hci h4 deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define H4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hci h4 deframer check failed");

`endif

[hdl/hci_h4_pkg.sv]
// Shared types, codes and constants of the HCI UART H4 deframer.
// Depends on nothing; every module of the block imports it.
package hci_h4_pkg;

    // Statistics counters.
    localparam int COUNTER_WIDTH = 32;
    localparam int NUM_COUNTERS  = 7;

    localparam logic [2:0] CNT_BYTES     = 3'd0;
    localparam logic [2:0] CNT_DESYNC    = 3'd1;
    localparam logic [2:0] CNT_OVERSIZE  = 3'd2;
    // A completed packet of type t counts at CNT_TYPE_BASE + t.
    localparam logic [2:0] CNT_TYPE_BASE = 3'd2;

    // Input operations.
    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Packet type codes as they appear on the wire.
    localparam logic [2:0] TYPE_NONE  = 3'd0;
    localparam logic [2:0] TYPE_CMD   = 3'd1;
    localparam logic [2:0] TYPE_ACL   = 3'd2;
    localparam logic [2:0] TYPE_SCO   = 3'd3;
    localparam logic [2:0] TYPE_EVENT = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_PACKET  = 2'd0;
    localparam logic [1:0] KIND_OOB     = 2'd1;
    localparam logic [1:0] KIND_COUNTER = 2'd2;

    // Work passed from the front end to the back end.
    localparam logic [1:0] JOB_HEADER  = 2'd0;
    localparam logic [1:0] JOB_PAYLOAD = 2'd1;
    localparam logic [1:0] JOB_OOB     = 2'd2;
    localparam logic [1:0] JOB_COUNTER = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  REG_OOB_ENABLE  = 2'd0;
    localparam logic [1:0]  REG_ACL_MAX     = 2'd1;
    localparam logic [1:0]  REG_SHORT_MAX   = 2'd2;
    localparam int          CFG_DATA_WIDTH  = 16;
    localparam logic [15:0] ACL_MAX_RESET   = 16'd1021;
    localparam logic [7:0]  SHORT_MAX_RESET = 8'd255;

    // Job queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_in;
        logic [2:0] counter_select;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  packet_type;
        logic [7:0]  data_out;
        logic        packet_start;
        logic        packet_end;
        logic        run_end;
        logic [31:0] counter_value;
    } result_t;

    // The word holds header bytes (byte 0 lowest), a single data byte,
    // or a counter value, depending on the job kind.
    typedef struct packed {
        logic [1:0]  jkind;
        logic [2:0]  ptype;
        logic [1:0]  last_idx;
        logic        pkt_end;
        logic [31:0] word;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[hdl/hci_h4_queue.sv]
// Short job queue that decouples the framing front end from the result back end.
// Depends on hci_h4_pkg.
module hci_h4_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hci_h4_pkg::job_t  push_job,
    input  logic              pop,
    output hci_h4_pkg::job_t  head,
    output hci_h4_pkg::q_stat_t stat
);
    import hci_h4_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage carries payload only, so it has no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hdl/hci_h4_front.sv]
// Front end: accepts input transactions, tracks H4 framing, keeps the
// statistics counters and configuration, and queues result jobs.
// Depends on hci_h4_pkg.
module hci_h4_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  hci_h4_pkg::item_t     item,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [hci_h4_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    output logic                  q_push,
    output hci_h4_pkg::job_t      q_job,
    input  hci_h4_pkg::q_stat_t   q_stat
);
    import hci_h4_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  type_reg, type_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [1:0]  last_idx_reg, last_idx_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  hb_reg [4];

    logic        oob_en_reg;
    logic [15:0] acl_max_reg;
    logic [7:0]  short_max_reg;

    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_COUNTERS];
    logic [2:0]               inc [NUM_COUNTERS];

    logic        accept;
    logic        hdr_write;
    logic [7:0]  hv [4];
    logic [15:0] hdr_len;
    logic [15:0] hdr_max;
    logic [2:0]  type_cnt_idx;

    assign item_stall   = q_stat.full;
    assign accept       = item_valid && !item_stall;
    assign type_cnt_idx = CNT_TYPE_BASE + type_reg;

    // Header as it stands once the incoming byte is placed.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            hv[i] = (hdr_idx_reg == 2'(i)) ? item.data_in : hb_reg[i];
        end
    end

    // Payload length and its limit for the current packet type.
    always_comb
    begin
        case (type_reg)
            TYPE_ACL:
            begin
                hdr_len = {hv[3], hv[2]};
                hdr_max = acl_max_reg;
            end
            TYPE_EVENT:
            begin
                hdr_len = {8'd0, hv[1]};
                hdr_max = {8'd0, short_max_reg};
            end
            default:
            begin
                hdr_len = {8'd0, hv[2]};
                hdr_max = {8'd0, short_max_reg};
            end
        endcase
    end

    // Framing state machine, job generation and counter increments.
    always_comb
    begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        hdr_idx_next  = hdr_idx_reg;
        last_idx_next = last_idx_reg;
        left_next     = left_reg;
        hdr_write     = 1'b0;
        q_push        = 1'b0;
        q_job.jkind    = JOB_PAYLOAD;
        q_job.ptype    = type_reg;
        q_job.last_idx = last_idx_reg;
        q_job.pkt_end  = 1'b0;
        q_job.word     = {24'd0, item.data_in};
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            inc[i] = 3'd0;
        end

        if (accept)
        begin
            case (item.op)
                OP_FEED:
                begin
                    inc[CNT_BYTES] = 3'd1;
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            hdr_write = 1'b1;
                            if (hdr_idx_reg == last_idx_reg)
                            begin
                                if (hdr_len > hdr_max)
                                begin
                                    // Oversize: drop type byte and header as desync.
                                    inc[CNT_OVERSIZE] = 3'd1;
                                    inc[CNT_DESYNC]   = {1'b0, last_idx_reg} + 3'd2;
                                    phase_next        = PH_IDLE;
                                    type_next         = TYPE_NONE;
                                end
                                else
                                begin
                                    q_push        = 1'b1;
                                    q_job.jkind   = JOB_HEADER;
                                    q_job.pkt_end = (hdr_len == '0);
                                    q_job.word    = {hv[3], hv[2], hv[1], hv[0]};
                                    if (hdr_len == '0)
                                    begin
                                        inc[type_cnt_idx] = 3'd1;
                                        phase_next        = PH_IDLE;
                                        type_next         = TYPE_NONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_PAYLOAD;
                                        left_next  = hdr_len;
                                    end
                                end
                            end
                            else
                            begin
                                hdr_idx_next = hdr_idx_reg + 1'b1;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            q_push        = 1'b1;
                            q_job.pkt_end = (left_reg == 16'd1);
                            if (left_reg == 16'd1)
                            begin
                                inc[type_cnt_idx] = 3'd1;
                                phase_next        = PH_IDLE;
                                type_next         = TYPE_NONE;
                            end
                            else
                            begin
                                left_next = left_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // Idle: a type byte opens a header, anything else is unknown.
                            if (item.data_in >= 8'(TYPE_CMD) && item.data_in <= 8'(TYPE_EVENT))
                            begin
                                phase_next   = PH_HEADER;
                                type_next    = item.data_in[2:0];
                                hdr_idx_next = 2'd0;
                                case (item.data_in[2:0])
                                    TYPE_ACL:   last_idx_next = 2'd3;
                                    TYPE_EVENT: last_idx_next = 2'd1;
                                    default:    last_idx_next = 2'd2;
                                endcase
                            end
                            else if (oob_en_reg)
                            begin
                                q_push      = 1'b1;
                                q_job.jkind = JOB_OOB;
                                q_job.ptype = TYPE_NONE;
                            end
                            else
                            begin
                                inc[CNT_DESYNC] = 3'd1;
                            end
                        end
                    endcase
                end
                OP_READ:
                begin
                    q_push      = 1'b1;
                    q_job.jkind = JOB_COUNTER;
                    q_job.ptype = TYPE_NONE;
                    if (item.counter_select < 3'(NUM_COUNTERS))
                    begin
                        q_job.word = 32'(cnt_reg[item.counter_select]);
                    end
                    else
                    begin
                        q_job.word = '0;
                    end
                end
                OP_CLEAR:
                begin
                    phase_next = PH_IDLE;
                    type_next  = TYPE_NONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state, configuration and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            type_reg      <= TYPE_NONE;
            hdr_idx_reg   <= '0;
            last_idx_reg  <= '0;
            left_reg      <= '0;
            oob_en_reg    <= 1'b0;
            acl_max_reg   <= ACL_MAX_RESET;
            short_max_reg <= SHORT_MAX_RESET;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            hdr_idx_reg  <= hdr_idx_next;
            last_idx_reg <= last_idx_next;
            left_reg     <= left_next;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= cnt_reg[i] + COUNTER_WIDTH'(inc[i]);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OOB_ENABLE: oob_en_reg    <= cfg_data[0];
                    REG_ACL_MAX:    acl_max_reg   <= cfg_data[15:0];
                    REG_SHORT_MAX:  short_max_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Header byte store; always written before it is read.
    always_ff @(posedge clk)
    begin
        if (hdr_write)
        begin
            hb_reg[hdr_idx_reg] <= item.data_in;
        end
    end

endmodule

[hdl/hci_h4_back.sv]
// Back end: takes jobs from the queue and plays them out as result
// transactions through an output register, one result per cycle unless stalled.
// Depends on hci_h4_pkg.
module hci_h4_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hci_h4_pkg::q_stat_t q_stat,
    input  hci_h4_pkg::job_t    q_head,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output hci_h4_pkg::result_t result
);
    import hci_h4_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;
    logic [1:0] burst_idx_reg, burst_idx_next;
    logic       load;
    logic       burst_last;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign load       = !q_stat.empty && (!out_valid_reg || !result_stall);
    assign burst_last = (q_head.jkind != JOB_HEADER) || (burst_idx_reg == q_head.last_idx);
    assign q_pop      = load && burst_last;

    // Build the next result from the head job.
    always_comb
    begin
        out_next               = out_reg;
        out_valid_next         = out_valid_reg && result_stall;
        burst_idx_next         = burst_idx_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_next.kind          = KIND_PACKET;
            out_next.packet_type   = q_head.ptype;
            out_next.data_out      = q_head.word[7:0];
            out_next.packet_start  = 1'b0;
            out_next.packet_end    = q_head.pkt_end;
            out_next.run_end       = 1'b1;
            out_next.counter_value = '0;
            burst_idx_next         = burst_last ? 2'd0 : burst_idx_reg + 1'b1;
            case (q_head.jkind)
                JOB_HEADER:
                begin
                    out_next.data_out     = q_head.word[{burst_idx_reg, 3'b000} +: 8];
                    out_next.packet_start = (burst_idx_reg == 2'd0);
                    out_next.packet_end   = burst_last && q_head.pkt_end;
                    out_next.run_end      = burst_last;
                end
                JOB_OOB:
                begin
                    out_next.kind        = KIND_OOB;
                    out_next.packet_type = TYPE_NONE;
                    out_next.packet_end  = 1'b0;
                end
                JOB_COUNTER:
                begin
                    out_next.kind          = KIND_COUNTER;
                    out_next.packet_type   = TYPE_NONE;
                    out_next.data_out      = '0;
                    out_next.packet_end    = 1'b0;
                    out_next.counter_value = q_head.word;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            burst_idx_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            burst_idx_reg <= burst_idx_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[hdl/hci_uart_h4_deframer.sv]
// Top level of the HCI UART H4 deframer: front end, job queue, back end.
// Depends on hci_h4_pkg, hci_h4_front, hci_h4_queue and hci_h4_back.
//
//  Channel   Signals                          Direction  Payload
//  item      item_valid/item_stall/item       in         op, data_in, counter_select
//  result    result_valid/result_stall/result out        kind ... counter_value
//  config    cfg_we/cfg_index/cfg_data        in         3 registers, write only
//
// The front end takes one item per cycle while the job queue has room.
// A byte completing a header within its limit yields 2 to 4 results, one per
// unstalled cycle of the back end; any other item yields at most one result.
// A result stall holds the output register and fills the four-entry queue,
// and a full queue raises item_stall. Reset takes effect at once, with no sweep.
module hci_uart_h4_deframer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hci_h4_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output hci_h4_pkg::result_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [hci_h4_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import hci_h4_pkg::*;

    logic    q_push;
    logic    q_pop;
    job_t    q_job;
    job_t    q_head;
    q_stat_t q_stat;

    hci_h4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_push     (q_push),
        .q_job      (q_job),
        .q_stat     (q_stat)
    );

    hci_h4_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    hci_h4_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[hdl/hci_h4_checker.sv]
// Port-level checker for the H4 deframer and the bind that attaches it.
// Depends on hci_h4_pkg and hci_uart_h4_deframer_assert.svh.
`include "hci_uart_h4_deframer_assert.svh"

module hci_h4_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input hci_h4_pkg::result_t result
);
    import hci_h4_pkg::*;

    logic start_ok;
    logic lone_ok;

    // A packet start must be a header byte that is not the last of its burst.
    assign start_ok = (result.kind == KIND_PACKET) && !result.run_end;

    // A non-packet result ends its run and carries no packet type or end mark.
    assign lone_ok = result.run_end && (result.packet_type == TYPE_NONE) && !result.packet_end;

    // A stalled result stays valid.
    `H4_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid)

    // A stalled result keeps its payload.
    `H4_ASSERT_NEXT(a_hold_data, result_valid && result_stall, $stable(result))

    // A packet start is a header byte and never the last result of its burst.
    `H4_ASSERT_NOW(a_start_in_burst, result_valid && result.packet_start, start_ok)

    // Out-of-band and counter results stand alone and carry no packet type.
    `H4_ASSERT_NOW(a_single_result, result_valid && (result.kind != KIND_PACKET), lone_ok)

endmodule

bind hci_uart_h4_deframer hci_h4_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[verif/hci_uart_h4_deframer_tb.sv]
// Self-checking testbench of the HCI UART H4 deframer, top module hci_uart_h4_deframer_tb.
// Depends on hci_h4_pkg and hci_uart_h4_deframer. It keeps its own copy of the
// deframing state to predict every result, and it idles and stalls both channels at random.
module hci_uart_h4_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hci_h4_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [2:0] SELECT_UNUSED = 3'd7;
    localparam int         HOLD_CYCLES   = 60;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         SEGMENT_ITEMS = 38;
    localparam int         NUM_SEGMENTS  = 6;
    localparam result_t    NO_RESULT     = '0;

    typedef enum logic [1:0] {FS_IDLE, FS_HEADER, FS_PAYLOAD} frame_state_t;
    typedef enum logic [1:0] {ROW_FREE, ROW_FIXED, ROW_OOB_ON} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        item_t     stim;
        result_t   fixed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    // Typed expectation that travels with the transaction being offered.
    logic row_fixed;
    result_t row_expect;

    // Predicted configuration and deframing state.
    logic oob_on;
    logic [15:0] lim_acl;
    logic [7:0] lim_short;
    frame_state_t fs;
    logic [2:0] cur_type;
    int hdr_need;
    int taken;
    int pay_need;
    logic [7:0] hdr [4];
    logic [COUNTER_WIDTH-1:0] stat_count [NUM_COUNTERS];

    result_t step_results[$];
    result_t pending_results[$];
    item_t plan[$];
    row_t directed_rows[$];
    int mismatches = 0;
    int send_gap_pct = 38;
    int stall_pct = 81;
    int hold_asked = 0;
    int accepted_items = 0;

    hci_uart_h4_deframer dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result builders and stimulus helpers.
    function automatic string describe(input result_t r);
        return $sformatf("kind %0d type %0d data %02h start %0b end %0b run_end %0b count %0d",
                         r.kind, r.packet_type, r.data_out, r.packet_start, r.packet_end,
                         r.run_end, r.counter_value);
    endfunction

    function automatic result_t counter_is(input logic [31:0] v);
        result_t r;
        r = '0;
        r.kind = KIND_COUNTER;
        r.run_end = 1'b1;
        r.counter_value = v;
        return r;
    endfunction

    function automatic result_t oob_is(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_OOB;
        r.data_out = b;
        r.run_end = 1'b1;
        return r;
    endfunction

    function automatic item_t feed_of(input logic [7:0] b);
        item_t it;
        it.op = OP_FEED;
        it.data_in = b;
        it.counter_select = $urandom_range(7);
        return it;
    endfunction

    function automatic item_t read_of(input logic [2:0] sel);
        item_t it;
        it.op = OP_READ;
        it.data_in = $urandom_range(255);
        it.counter_select = sel;
        return it;
    endfunction

    function automatic item_t any_of(input logic [1:0] op);
        item_t it;
        it.op = op;
        it.data_in = $urandom_range(255);
        it.counter_select = $urandom_range(7);
        return it;
    endfunction

    task automatic add_row(input row_kind_t kind, input item_t it, input result_t fx);
        row_t r;
        r.kind = kind;
        r.stim = it;
        r.fixed = fx;
        directed_rows.push_back(r);
    endtask

    // Predictor: deframes one transaction into step_results.
    task automatic emit(input logic [1:0] kind, input logic [2:0] ptype, input logic [7:0] data,
                        input logic first, input logic last, input logic [31:0] cval);
        result_t r;
        r.kind = kind;
        r.packet_type = ptype;
        r.data_out = data;
        r.packet_start = first;
        r.packet_end = last;
        r.run_end = 1'b0;
        r.counter_value = cval;
        step_results.push_back(r);
    endtask

    task automatic return_idle();
        fs = FS_IDLE;
        cur_type = TYPE_NONE;
        hdr_need = 0;
        pay_need = 0;
        taken = 0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] len;
        logic [15:0] lim;
        stat_count[CNT_BYTES] += 1;
        case (fs)
            FS_HEADER:
            begin
                hdr[taken % 4] = b;
                taken++;
                if (taken >= hdr_need)
                begin
                    if (cur_type == TYPE_ACL)
                    begin
                        len = {hdr[3], hdr[2]};
                        lim = lim_acl;
                    end
                    else
                    begin
                        len = {8'h00, (cur_type == TYPE_EVENT) ? hdr[1] : hdr[2]};
                        lim = {8'h00, lim_short};
                    end
                    // An oversize header is dropped whole and counted as lost sync.
                    if (len > lim)
                    begin
                        stat_count[CNT_OVERSIZE] += 1;
                        stat_count[CNT_DESYNC] += 1 + hdr_need;
                        return_idle();
                    end
                    else
                    begin
                        for (int i = 0; i < hdr_need; i++)
                            emit(KIND_PACKET, cur_type, hdr[i], i == 0,
                                 i == hdr_need - 1 && len == 0, '0);
                        if (len == 0)
                        begin
                            stat_count[CNT_TYPE_BASE + cur_type] += 1;
                            return_idle();
                        end
                        else
                        begin
                            fs = FS_PAYLOAD;
                            pay_need = len;
                            taken = 0;
                        end
                    end
                end
            end
            FS_PAYLOAD:
            begin
                taken++;
                emit(KIND_PACKET, cur_type, b, 1'b0, taken >= pay_need, '0);
                if (taken >= pay_need)
                begin
                    stat_count[CNT_TYPE_BASE + cur_type] += 1;
                    return_idle();
                end
            end
            default:
            begin
                // In idle a type code opens a header; anything else is out of band if enabled, else lost sync.
                if (b >= TYPE_CMD && b <= TYPE_EVENT)
                begin
                    fs = FS_HEADER;
                    cur_type = b[2:0];
                    hdr_need = (b == TYPE_ACL) ? 4 : (b == TYPE_EVENT) ? 2 : 3;
                    pay_need = 0;
                    taken = 0;
                end
                else if (oob_on)
                    emit(KIND_OOB, TYPE_NONE, b, 1'b0, 1'b0, '0);
                else
                    stat_count[CNT_DESYNC] += 1;
            end
        endcase
    endtask

    task automatic deframe_item(input item_t it);
        result_t r;
        step_results.delete();
        case (it.op)
            OP_FEED:  deframe_byte(it.data_in);
            OP_READ:  emit(KIND_COUNTER, TYPE_NONE, 8'h00, 1'b0, 1'b0,
                           (it.counter_select == SELECT_UNUSED) ? 32'h0
                                                                : stat_count[it.counter_select]);
            OP_CLEAR: return_idle();
            default:  ;
        endcase
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.run_end = 1'b1;
            step_results.push_back(r);
        end
    endtask

    // Scoreboard: check each result transaction, then predict each item transaction.
    always @(posedge clk)
    begin : scoreboard_check
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %s",
                             $time, describe(result));
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, describe(want), describe(result));
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                deframe_item(item);
                if (row_fixed)
                    pending_results.push_back(row_expect);
                else
                    foreach (step_results[i])
                        pending_results.push_back(step_results[i]);
            end
        end
    end

    // Receiver side: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin : stall_driver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one item transaction, with a random gap first, and wait for its handshake.
    task automatic offer(input item_t it, input logic fixed, input result_t fx);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        row_fixed <= fixed;
        row_expect <= fx;
        @(posedge clk);
        while (!(item_valid && !item_stall))
            @(posedge clk);
        @(negedge clk);
        if (it.op != OP_UNUSED)
            accepted_items++;
    endtask

    // Wait until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input logic oob, input logic [15:0] acl, input logic [7:0] shrt);
        cfg_we <= 1'b1;
        cfg_index <= REG_OOB_ENABLE;
        cfg_data <= {15'h0000, oob};
        @(negedge clk);
        cfg_index <= REG_ACL_MAX;
        cfg_data <= acl;
        @(negedge clk);
        cfg_index <= REG_SHORT_MAX;
        cfg_data <= {8'h00, shrt};
        @(negedge clk);
        cfg_we <= 1'b0;
        oob_on = oob;
        lim_acl = acl;
        lim_short = shrt;
        @(negedge clk);
    endtask

    // Plan one random unit: mostly well-formed packets, the rest noise and broken framing.
    task automatic plan_random_unit();
        int pick;
        int hlen;
        int cut;
        logic [2:0] t;
        logic [16:0] lim;
        logic [16:0] full;
        logic [16:0] len;
        logic [7:0] hb [4];
        pick = $urandom_range(99);
        t = $urandom_range(TYPE_CMD, TYPE_EVENT);
        hlen = (t == TYPE_ACL) ? 4 : (t == TYPE_EVENT) ? 2 : 3;
        if (pick < 62)
        begin
            lim = (t == TYPE_ACL) ? {1'b0, lim_acl} : {9'h000, lim_short};
            full = (t == TYPE_ACL) ? 17'hFFFF : 17'hFF;
            case ($urandom_range(9))
                6:       len = lim;
                7:       len = lim + 1;
                8:       len = $urandom_range(full);
                9:       len = full;
                default: len = $urandom_range(6);
            endcase
            if (len > full)
                len = full;
            for (int i = 0; i < 4; i++)
                hb[i] = $urandom_range(255);
            if (t == TYPE_ACL)
            begin
                hb[2] = len[7:0];
                hb[3] = len[15:8];
            end
            else if (t == TYPE_EVENT)
                hb[1] = len[7:0];
            else
                hb[2] = len[7:0];
            plan.push_back(feed_of({5'h00, t}));
            for (int i = 0; i < hlen; i++)
                plan.push_back(feed_of(hb[i]));
            if (len <= lim)
            begin
                // Long payloads are cut short by a framing reset to keep the run brief.
                if (len > 8)
                    cut = $urandom_range(1, 3);
                else if (len > 0 && $urandom_range(9) == 0)
                    cut = $urandom_range(len - 1);
                else
                    cut = len;
                for (int i = 0; i < cut; i++)
                begin
                    if ($urandom_range(19) == 0)
                        plan.push_back(read_of($urandom_range(7)));
                    plan.push_back(feed_of($urandom_range(255)));
                end
                if (cut < len)
                    plan.push_back(any_of(OP_CLEAR));
            end
        end
        else if (pick < 72)
            plan.push_back(read_of($urandom_range(7)));
        else if (pick < 80)
        begin
            plan.push_back(feed_of($urandom_range(255)));
            if (plan[plan.size() - 1].data_in inside {[TYPE_CMD:TYPE_EVENT]})
                plan.push_back(any_of(OP_CLEAR));
        end
        else if (pick < 84)
            plan.push_back(any_of(OP_CLEAR));
        else if (pick < 87)
            plan.push_back(any_of(OP_UNUSED));
        else
        begin
            // A header cut off part way, sometimes with a counter read inside it.
            plan.push_back(feed_of({5'h00, t}));
            cut = $urandom_range(hlen - 1);
            for (int i = 0; i < cut; i++)
                plan.push_back(feed_of($urandom_range(255)));
            if ($urandom_range(1) == 1)
                plan.push_back(read_of($urandom_range(7)));
            plan.push_back(any_of(OP_CLEAR));
        end
    endtask

    // Main sequence: reset, directed table, then random segments over several settings.
    initial
    begin : main_sequence
        item_t nxt;
        int goal;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        row_fixed = 1'b0;
        row_expect = '0;
        cfg_we = 1'b0;
        cfg_index = REG_OOB_ENABLE;
        cfg_data = '0;
        oob_on = 1'b0;
        lim_acl = ACL_MAX_RESET;
        lim_short = SHORT_MAX_RESET;
        for (int i = 0; i < NUM_COUNTERS; i++)
            stat_count[i] = '0;
        for (int i = 0; i < 4; i++)
            hdr[i] = '0;
        return_idle();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: counters after reset, dropped and out-of-band bytes,
        // the unused op, a zero-payload command, an event, an oversize ACL header,
        // and an SCO packet at the length limit ended early by a framing reset.
        add_row(ROW_FIXED, read_of(CNT_BYTES), counter_is(32'd0));
        add_row(ROW_FIXED, read_of(SELECT_UNUSED), counter_is(32'd0));
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'hFF), NO_RESULT);
        add_row(ROW_FIXED, read_of(CNT_DESYNC), counter_is(32'd2));
        add_row(ROW_FREE, any_of(OP_UNUSED), NO_RESULT);
        add_row(ROW_FIXED, read_of(CNT_BYTES), counter_is(32'd2));
        add_row(ROW_OOB_ON, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FIXED, feed_of(8'hFF), oob_is(8'hFF));
        add_row(ROW_FREE, feed_of({5'h00, TYPE_CMD}), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h03), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h0C), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of({5'h00, TYPE_EVENT}), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h0E), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h01), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h7F), NO_RESULT);
        add_row(ROW_FREE, feed_of({5'h00, TYPE_ACL}), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'hFE), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h03), NO_RESULT);
        add_row(ROW_FIXED, read_of(CNT_OVERSIZE), counter_is(32'd1));
        add_row(ROW_FREE, feed_of({5'h00, TYPE_SCO}), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h00), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'hFF), NO_RESULT);
        add_row(ROW_FREE, feed_of(8'h42), NO_RESULT);
        add_row(ROW_FREE, any_of(OP_CLEAR), NO_RESULT);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_OOB_ON)
            begin
                settle();
                write_settings(1'b1, lim_acl, lim_short);
            end
            else
                offer(directed_rows[i].stim, directed_rows[i].kind == ROW_FIXED,
                      directed_rows[i].fixed);
        end

        // Random segments: two settings for each idling mode.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            settle();
            case (seg / 2)
                0:
                begin
                    send_gap_pct = 38;
                    stall_pct = 81;
                end
                1:
                begin
                    send_gap_pct = 81;
                    stall_pct = 38;
                end
                default:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            case (seg)
                0:       write_settings(1'b0, ACL_MAX_RESET, SHORT_MAX_RESET);
                1:       write_settings(1'b1, 16'hFFFF, 8'h00);
                2:       write_settings(1'b0, 16'h0000, 8'hFF);
                3:       write_settings(1'b1, 16'd12, 8'd6);
                4:       write_settings(1'b0, 16'd6, 8'd12);
                default: write_settings(1'b1, 16'hFFFF, 8'hFF);
            endcase
            // With no idling, a long receiver hold-off backs the block up to its input.
            if (seg / 2 == 2)
                hold_asked++;
            goal = accepted_items + SEGMENT_ITEMS;
            while (accepted_items < goal)
            begin
                plan_random_unit();
                while (plan.size() != 0)
                begin
                    nxt = plan.pop_front();
                    offer(nxt, 1'b0, NO_RESULT);
                end
            end
        end

        settle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/hci_h4_pkg.sv
hdl/hci_h4_queue.sv
hdl/hci_h4_front.sv
hdl/hci_h4_back.sv
hdl/hci_uart_h4_deframer.sv
hdl/hci_h4_checker.sv
verif/hci_uart_h4_deframer_tb.sv
